// ===== hw/rtl/euler_rotation_matrix_core_assert.svh =====
// Assertion macros for the Euler rotation matrix core.
// Used by the top level; clock clk and reset arst_n must be in scope.
`ifndef EULER_ROTATION_MATRIX_CORE_ASSERT_SVH
`define EULER_ROTATION_MATRIX_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ERM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("erm invariant violated");
`define ERM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("erm sequence violated");
`else
`define ERM_ASSERT(lbl, prop)
`define ERM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/erm_pkg.sv =====
// Shared types, constants and tables for the Euler rotation matrix core.
// No dependencies.
package erm_pkg;

	// CORDIC working width: Q30 values plus headroom
	localparam int CORD_W = 33;

	localparam logic [1:0] ROW_LAST = 2'd2;

	// gain-compensated start value, Q30
	localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 33'sd652032874;

	// floor(u/45) = (u * RECIP45) >> 32, exact for u < 2^25
	localparam logic [26:0] RECIP45 = 27'd95443718;
	// offset that keeps the dividend positive: 45 * 2^18
	localparam logic [24:0] DIV_OFFSET = 25'd11796480;
	localparam logic [31:0] QUOT_OFFSET = 32'd262144;

	typedef struct packed {
		logic signed [CORD_W-1:0] x;
		logic signed [CORD_W-1:0] y;
		logic signed [CORD_W-1:0] z;
		logic                     neg;
	} cord_t;

	typedef struct packed {
		logic signed [17:0] c0;
		logic signed [17:0] c1;
		logic signed [17:0] c2;
	} row_t;

	// atan(2^-i) in 2^32-per-turn units
	function automatic logic signed [CORD_W-1:0] atan_turn(input int i);
		logic signed [CORD_W-1:0] a;
		case (i)
			0: a = 33'sd536870912;
			1: a = 33'sd316933406;
			2: a = 33'sd167458907;
			3: a = 33'sd85004756;
			4: a = 33'sd42667331;
			5: a = 33'sd21354465;
			6: a = 33'sd10679838;
			7: a = 33'sd5340245;
			8: a = 33'sd2670163;
			9: a = 33'sd1335087;
			10: a = 33'sd667544;
			11: a = 33'sd333772;
			12: a = 33'sd166886;
			13: a = 33'sd83443;
			14: a = 33'sd41722;
			15: a = 33'sd20861;
			16: a = 33'sd10430;
			17: a = 33'sd5215;
			18: a = 33'sd2608;
			19: a = 33'sd1304;
			20: a = 33'sd652;
			21: a = 33'sd326;
			22: a = 33'sd163;
			23: a = 33'sd81;
			24: a = 33'sd41;
			25: a = 33'sd20;
			26: a = 33'sd10;
			27: a = 33'sd5;
			28: a = 33'sd3;
			29: a = 33'sd1;
			30: a = 33'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

	// fractional part of a turn for remainder b (0..44): floor(b * 2^k / 45)
	function automatic logic [31:0] frac_turn(input logic [5:0] b, input int k);
		longint n;
		n = longint'(b) << k;
		return 32'(n / 45);
	endfunction

endpackage

// ===== hw/rtl/euler_rotation_matrix_core.sv =====
// Euler rotation matrix core. Takes three angles in degrees and returns
// M = Rx*Ry*Rz as three row transactions (row 0, 1, 2, last_row on row 2),
// coefficients signed Q2.16. A new angle triple can be accepted every cycle
// while in_ready is high; sustained throughput is one triple per three rows,
// set by the output channel, which moves one row per cycle while out_ready is
// high. From input to first row: angle reduction and rounding registers around
// the CORDIC cell chain (one cell per stage), matrix product registers, one
// output register. The pipeline stalls as a whole only while the output
// register still holds rows not yet taken.
`include "euler_rotation_matrix_core_assert.svh"

module euler_rotation_matrix_core import erm_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 8,
	parameter int COEF_FRAC_BITS  = 16,
	parameter int CORDIC_STAGES   = 18
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] angle_x,
	input  logic signed [23:0] angle_y,
	input  logic signed [23:0] angle_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         row_index,
	output logic signed [17:0] coef_col0,
	output logic signed [17:0] coef_col1,
	output logic signed [17:0] coef_col2,
	output logic               last_row
);

	localparam int CW  = COEF_FRAC_BITS + 3;
	localparam int PW  = 2 * CW;
	localparam int LAT = CORDIC_STAGES + 9;
	localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (COEF_FRAC_BITS - 1);

	logic [LAT-1:0] vld_q;
	logic adv, load;
	logic ovalid_q;
	logic [1:0] row_q;
	row_t obuf_q [3];
	row_t f_s4 [3];

	logic signed [CW-1:0] cx, sx, cy, sy, cz, sz;
	logic signed [CW-1:0] cx_s1, sx_s1, cy_s1, sy_s1, cz_s1, sz_s1, cz_s2, sz_s2;
	logic signed [PW-1:0] pxy_s1, pcs_s1, psc_s1, pcc_s1;
	logic signed [CW-1:0] m_s2 [3][3];
	logic signed [PW-1:0] a_s3 [3], b_s3 [3], c_s3 [3], d_s3 [3];
	logic signed [CW-1:0] m2_s3 [3];

	function automatic logic signed [CW-1:0] rnd(input logic signed [PW:0] v);
		logic signed [PW:0] h;
		h = (v + HALF) >>> COEF_FRAC_BITS;
		return CW'(h);
	endfunction

	function automatic logic signed [17:0] sat(input logic signed [CW-1:0] v);
		logic signed [33:0] w;
		w = 34'(v);
		if (w > 34'sd131071) return 18'sd131071;
		if (w < -34'sd131072) return -18'sd131072;
		return 18'(w);
	endfunction

	// pipeline control: advance unless the finished matrix cannot be unloaded
	assign load     = vld_q[LAT-1] && (!ovalid_q || (out_ready && row_q == ROW_LAST));
	assign adv      = !vld_q[LAT-1] || load;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	// three axis units in parallel
	erm_axis #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)) u_ax_x (
		.clk(clk), .en(adv), .angle(angle_x), .cos_val(cx), .sin_val(sx));
	erm_axis #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)) u_ax_y (
		.clk(clk), .en(adv), .angle(angle_y), .cos_val(cy), .sin_val(sy));
	erm_axis #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)) u_ax_z (
		.clk(clk), .en(adv), .angle(angle_z), .cos_val(cz), .sin_val(sz));

	// products of Rx*Ry
	always_ff @(posedge clk) begin
		if (adv) begin
			pxy_s1 <= sx * sy;
			pcs_s1 <= cx * sy;
			psc_s1 <= sx * cy;
			pcc_s1 <= cx * cy;
			cx_s1 <= cx; sx_s1 <= sx; cy_s1 <= cy; sy_s1 <= sy;
			cz_s1 <= cz; sz_s1 <= sz;
		end
	end

	// rounded Rx*Ry
	always_ff @(posedge clk) begin
		if (adv) begin
			m_s2[0][0] <= cy_s1;
			m_s2[0][1] <= '0;
			m_s2[0][2] <= -sy_s1;
			m_s2[1][0] <= rnd((PW+1)'(pxy_s1));
			m_s2[1][1] <= cx_s1;
			m_s2[1][2] <= rnd((PW+1)'(psc_s1));
			m_s2[2][0] <= rnd((PW+1)'(pcs_s1));
			m_s2[2][1] <= -sx_s1;
			m_s2[2][2] <= rnd((PW+1)'(pcc_s1));
			cz_s2 <= cz_s1;
			sz_s2 <= sz_s1;
		end
	end

	// products with Rz, one set per row
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				a_s3[r]  <= m_s2[r][0] * cz_s2;
				b_s3[r]  <= m_s2[r][1] * sz_s2;
				c_s3[r]  <= m_s2[r][0] * sz_s2;
				d_s3[r]  <= m_s2[r][1] * cz_s2;
				m2_s3[r] <= m_s2[r][2];
			end
		end
	end

	// final sums, rounding and saturation
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				f_s4[r].c0 <= sat(rnd((PW+1)'(a_s3[r]) - (PW+1)'(b_s3[r])));
				f_s4[r].c1 <= sat(rnd((PW+1)'(c_s3[r]) + (PW+1)'(d_s3[r])));
				f_s4[r].c2 <= sat(m2_s3[r]);
			end
		end
	end

	// output register: holds one matrix, sends a row per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			row_q    <= '0;
		end else if (load) begin
			ovalid_q <= 1'b1;
			row_q    <= '0;
		end else if (ovalid_q && out_ready) begin
			if (row_q == ROW_LAST) ovalid_q <= 1'b0;
			else row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) obuf_q <= f_s4;
	end

	always_comb begin
		case (row_q)
			2'd0: {coef_col0, coef_col1, coef_col2} = obuf_q[0];
			2'd1: {coef_col0, coef_col1, coef_col2} = obuf_q[1];
			default: {coef_col0, coef_col1, coef_col2} = obuf_q[2];
		endcase
	end

	assign out_valid = ovalid_q;
	assign row_index = row_q;
	assign last_row  = (row_q == ROW_LAST);

	`ERM_ASSERT(a_row_range, !ovalid_q || row_q <= ROW_LAST)
	`ERM_ASSERT(a_stall_cause, in_ready || (vld_q[LAT-1] && ovalid_q))
	`ERM_ASSERT_NEXT(a_drain, ovalid_q && out_ready && row_q == ROW_LAST && !load, !ovalid_q)
	`ERM_ASSERT_NEXT(a_hold, ovalid_q && !out_ready, ovalid_q && $stable(row_q))

endmodule

// ===== hw/rtl/erm_cordic_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation with its output register.
// Depends on erm_pkg.
module erm_cordic_cell import erm_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic  clk,
	input  logic  en,
	input  cord_t din,
	output cord_t dout
);

	logic signed [CORD_W-1:0] ys, xs, at;

	assign ys = din.y >>> STAGE;
	assign xs = din.x >>> STAGE;
	assign at = atan_turn(STAGE);

	// rotate toward zero residual angle
	always_ff @(posedge clk) begin
		if (en) begin
			dout.neg <= din.neg;
			if (!din.z[CORD_W-1]) begin
				dout.x <= din.x - ys;
				dout.y <= din.y + xs;
				dout.z <= din.z - at;
			end else begin
				dout.x <= din.x + ys;
				dout.y <= din.y - xs;
				dout.z <= din.z + at;
			end
		end
	end

endmodule

// ===== hw/rtl/erm_axis.sv =====
// Per-axis cosine/sine unit: angle reduction to a binary angle, quadrant
// fold, chain of CORDIC cells and final rounding. Depends on erm_pkg, erm_cordic_cell.
module erm_axis import erm_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = 8,
	parameter int COEF_FRAC_BITS  = 16,
	parameter int CORDIC_STAGES   = 18,
	localparam int CW = COEF_FRAC_BITS + 3
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [23:0]   angle,
	output logic signed [CW-1:0] cos_val,
	output logic signed [CW-1:0] sin_val
);

	localparam int K  = 29 - ANGLE_FRAC_BITS;
	localparam int RS = 30 - COEF_FRAC_BITS;
	localparam logic signed [32:0] P31 = 33'sd2147483648;
	localparam logic signed [31:0] P30 = 32'sd1073741824;

	logic [24:0] u_w, u_s1;
	logic [51:0] prod_w;
	logic [19:0] q_s1, q_s2;
	logic [24:0] b_w;
	logic [5:0]  b_s2;
	logic [31:0] aw, t_w, t_s3;
	logic [31:0] frac_tab [45];
	logic signed [31:0] ts;
	cord_t fold_w;
	cord_t chain [CORDIC_STAGES+1];
	logic signed [32:0] xf;

	// stage 1: quotient by 45 through reciprocal multiply
	assign u_w    = {angle[23], angle} + DIV_OFFSET;
	assign prod_w = u_w * RECIP45;

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= u_w;
			q_s1 <= prod_w[51:32];
		end
	end

	// stage 2: remainder
	assign b_w = u_s1 - 25'(q_s1) * 25'd45;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s2 <= q_s1;
			b_s2 <= b_w[5:0];
		end
	end

	// constant table of turn fractions, one entry per remainder
	for (genvar j = 0; j < 45; j++) begin : g_frac
		assign frac_tab[j] = frac_turn(6'(j), K);
	end

	// stage 3: binary angle, 2^32 per turn, modulo one turn
	assign aw  = {12'b0, q_s2} - QUOT_OFFSET;
	assign t_w = (aw << K) + frac_tab[b_s2];

	always_ff @(posedge clk) begin
		if (en) t_s3 <= t_w;
	end

	// stage 4: fold into [-90, 90] degrees, remember cosine sign
	assign ts = signed'(t_s3);

	always_comb begin
		fold_w.x   = CORDIC_GAIN;
		fold_w.y   = '0;
		fold_w.z   = {ts[31], ts};
		fold_w.neg = 1'b0;
		if (ts > P30) begin
			fold_w.z   = P31 - {ts[31], ts};
			fold_w.neg = 1'b1;
		end else if (ts < -P30) begin
			fold_w.z   = -P31 - {ts[31], ts};
			fold_w.neg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) chain[0] <= fold_w;
	end

	// CORDIC cell chain
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		erm_cordic_cell #(.STAGE(i)) u_cell (
			.clk  (clk),
			.en   (en),
			.din  (chain[i]),
			.dout (chain[i+1])
		);
	end

	// sign fix and rounding to coefficient format
	assign xf = chain[CORDIC_STAGES].neg ? -chain[CORDIC_STAGES].x : chain[CORDIC_STAGES].x;

	if (RS > 0) begin : g_rnd
		localparam logic signed [32:0] HALF = 33'sd1 <<< (RS - 1);
		logic signed [32:0] cr, sr;
		assign cr = (xf + HALF) >>> RS;
		assign sr = (chain[CORDIC_STAGES].y + HALF) >>> RS;
		always_ff @(posedge clk) begin
			if (en) begin
				cos_val <= CW'(cr);
				sin_val <= CW'(sr);
			end
		end
	end else begin : g_nornd
		always_ff @(posedge clk) begin
			if (en) begin
				cos_val <= CW'(xf);
				sin_val <= CW'(chain[CORDIC_STAGES].y);
			end
		end
	end

endmodule

// ===== tb/tb_euler_rotation_matrix_core.sv =====
// Testbench for euler_rotation_matrix_core: random and directed angle triples,
// each checked row by row against a fixed-point CORDIC/matrix predictor.
// Depends on erm_pkg and the core RTL only.
module tb_euler_rotation_matrix_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AFB = 8;
	localparam int CFB = 16;
	localparam int STAGES = 18;
	localparam int LATENCY = STAGES + 10;
	localparam longint SPAN = longint'(360) << AFB;

	typedef struct {
		logic signed [23:0] ax;
		logic signed [23:0] ay;
		logic signed [23:0] az;
	} angles_t;

	typedef struct {
		logic [1:0]         row;
		logic signed [17:0] c0;
		logic signed [17:0] c1;
		logic signed [17:0] c2;
		logic               last;
	} row_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [23:0] angle_x = '0, angle_y = '0, angle_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] row_index;
	logic signed [17:0] coef_col0, coef_col1, coef_col2;
	logic last_row;

	angles_t pending_angles[$];
	row_exp_t expected_rows[$];
	int mismatches = 0;
	int rows_seen = 0;
	int triples_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	euler_rotation_matrix_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.row_index(row_index), .coef_col0(coef_col0), .coef_col1(coef_col1),
		.coef_col2(coef_col2), .last_row(last_row)
	);

	always #6 clk = ~clk;

	// atan(2^-i) in 2^32-per-turn units
	localparam longint ATAN_TURNS[18] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215};

	function automatic longint rnd_shift(longint v, int s);
		if (s == 0)
			return v;
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// cosine and sine of an angle in degrees, Q(CFB)
	task automatic cordic_cos_sin(input logic signed [23:0] deg, output longint c,
			output longint s);
		longint r, t, x, y, nx;
		bit flip;
		r = longint'(deg) % SPAN;
		if (r < 0)
			r += SPAN;
		t = (r << 32) / SPAN;
		if (t >= (longint'(1) << 31))
			t -= longint'(1) << 32;
		flip = 1'b0;
		if (t > (longint'(1) << 30)) begin
			t = (longint'(1) << 31) - t;
			flip = 1'b1;
		end else if (t < -(longint'(1) << 30)) begin
			t = -(longint'(1) << 31) - t;
			flip = 1'b1;
		end
		x = 652032874;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			if (t >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				t -= ATAN_TURNS[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				t += ATAN_TURNS[i];
			end
			x = nx;
		end
		if (flip)
			x = -x;
		c = rnd_shift(x, 30 - CFB);
		s = rnd_shift(y, 30 - CFB);
	endtask

	function automatic logic signed [17:0] clamp_coef(longint v);
		if (v < -131072)
			return -18'sd131072;
		if (v > 131071)
			return 18'sd131071;
		return 18'(v);
	endfunction

	// M = Rx*Ry*Rz, queued as three expected rows
	task automatic predict_rotation(input angles_t a);
		longint m[3][3], rot[3][3], tmp[3][3], acc, c, s, one;
		logic signed [23:0] ang;
		row_exp_t e;
		one = longint'(1) << CFB;
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++)
				m[r][k] = (r == k) ? one : 0;
		for (int axis = 0; axis < 3; axis++) begin
			ang = (axis == 0) ? a.ax : (axis == 1) ? a.ay : a.az;
			cordic_cos_sin(ang, c, s);
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 3; k++)
					rot[r][k] = 0;
			case (axis)
				0: begin
					rot[0][0] = one; rot[1][1] = c; rot[1][2] = s;
					rot[2][1] = -s; rot[2][2] = c;
				end
				1: begin
					rot[0][0] = c; rot[0][2] = -s; rot[1][1] = one;
					rot[2][0] = s; rot[2][2] = c;
				end
				default: begin
					rot[0][0] = c; rot[0][1] = s; rot[1][0] = -s;
					rot[1][1] = c; rot[2][2] = one;
				end
			endcase
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 3; k++) begin
					acc = 0;
					for (int j = 0; j < 3; j++)
						acc += m[r][j] * rot[j][k];
					tmp[r][k] = rnd_shift(acc, CFB);
				end
			m = tmp;
		end
		for (int r = 0; r < 3; r++) begin
			e.row = 2'(r);
			e.c0 = clamp_coef(m[r][0]);
			e.c1 = clamp_coef(m[r][1]);
			e.c2 = clamp_coef(m[r][2]);
			e.last = (2'(r) == erm_pkg::ROW_LAST);
			expected_rows.push_back(e);
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("MISMATCH row %0d: %s got %0d expected %0d", rows_seen, what, got, want);
	endtask

	function automatic angles_t mk(longint x, longint y, longint z);
		angles_t a;
		a.ax = 24'(x);
		a.ay = 24'(y);
		a.az = 24'(z);
		return a;
	endfunction

	// random angle: mostly one or two turns, sometimes the full field
	function automatic logic signed [23:0] rand_angle();
		case ($urandom_range(0, 3))
			0: return 24'($urandom);
			1: return 24'(90 * ($urandom_range(0, 16) - 8) * 256);
			default: return 24'(int'($urandom_range(0, 2 * 92160)) - 92160);
		endcase
	endfunction

	// driver: presents queued triples, idles at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				triples_sent++;
			if (pending_angles.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				angles_t a;
				a = pending_angles.pop_front();
				predict_rotation(a);
				angle_x <= a.ax;
				angle_y <= a.ay;
				angle_z <= a.az;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: checks each accepted row and stalls the output at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				row_exp_t e;
				if (expected_rows.size() == 0) begin
					report_mismatch("unexpected row transaction, row_index", row_index, -1);
				end else begin
					e = expected_rows.pop_front();
					if (row_index !== e.row) report_mismatch("row_index", row_index, e.row);
					if (coef_col0 !== e.c0) report_mismatch("coef_col0", coef_col0, e.c0);
					if (coef_col1 !== e.c1) report_mismatch("coef_col1", coef_col1, e.c1);
					if (coef_col2 !== e.c2) report_mismatch("coef_col2", coef_col2, e.c2);
					if (last_row !== e.last) report_mismatch("last_row", last_row, e.last);
				end
				rows_seen++;
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		#20ms;
		$display("euler_rotation_matrix_core verification failed");
		$finish;
	end

	initial begin
		int idle_s[4];
		int idle_r[4];
		idle_s = '{0, 72, 0, 16};
		idle_r = '{0, 0, 72, 16};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero, field extremes, quadrant boundaries, wrap points
		pending_angles.push_back(mk(0, 0, 0));
		pending_angles.push_back(mk(-8388608, 8388607, -1));
		pending_angles.push_back(mk(8388607, -8388608, 1));
		pending_angles.push_back(mk(90*256, 0, 0));
		pending_angles.push_back(mk(0, 90*256, 0));
		pending_angles.push_back(mk(0, 0, 90*256));
		pending_angles.push_back(mk(180*256, 180*256, 180*256));
		pending_angles.push_back(mk(270*256, -90*256, -270*256));
		pending_angles.push_back(mk(360*256, -360*256, 720*256));
		pending_angles.push_back(mk(360*256 - 1, -360*256 + 1, 359*256));
		pending_angles.push_back(mk(-180*256, 45*256, -45*256));
		pending_angles.push_back(mk(90*256 + 1, 90*256 - 1, -90*256 - 1));
		pending_angles.push_back(mk(30*256, 60*256, 120*256));
		pending_angles.push_back(mk(-8388608, -8388608, -8388608));
		pending_angles.push_back(mk(8388607, 8388607, 8388607));
		pending_angles.push_back(mk(24'h555555, 24'h2AAAAA, 24'h0F0F0F));

		// random phases with differing idle and stall rates, plus a calm stretch
		for (int ph = 0; ph < 5; ph++) begin
			wait (pending_angles.size() == 0);
			send_idle_pct = idle_s[ph % 4];
			recv_stall_pct = idle_r[ph % 4];
			repeat (ph == 4 ? 50 : 100)
				pending_angles.push_back(mk(rand_angle(), rand_angle(), rand_angle()));
		end
		wait (pending_angles.size() == 0);
		@(posedge clk);
		wait (!in_valid);
		wait (expected_rows.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);

		$display("Covered %0d angle triples, %0d row transactions, idle/stall phases 0-72%%.",
			triples_sent, rows_seen);
		if (mismatches == 0 && expected_rows.size() == 0)
			$display("euler_rotation_matrix_core verification clean");
		else
			$display("euler_rotation_matrix_core verification failed");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/erm_pkg.sv
hw/rtl/erm_cordic_cell.sv
hw/rtl/erm_axis.sv
hw/rtl/euler_rotation_matrix_core.sv
tb/tb_euler_rotation_matrix_core.sv
